// File: rtl/ble_pkg.sv
// ---------------------------------------------------------------------------
// ble_pkg: shared types and constants of the battery level estimator
// Widths, the two charge curves and the handshake structs that pass
// between the estimator, its curve lanes and its shared divider.
// ---------------------------------------------------------------------------
`default_nettype none

package ble_pkg;

    // item shape
    localparam int NUM_SAMPLE_PORTS = 8;
    localparam int SAMPLES_PER_READ = 8;
    localparam int SAMPLE_W         = 12;
    localparam int SUM_W            = SAMPLE_W + $clog2(SAMPLES_PER_READ);

    // trimmed mean divides by the number of kept samples via a reciprocal
    localparam int KEPT             = SAMPLES_PER_READ - 2;
    localparam int RECIP_SH         = 18;
    localparam int RECIP_W          = RECIP_SH + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SH + KEPT - 1) / KEPT);

    // configuration
    localparam int CFG_W            = 4;
    localparam int CFG_ADDR_W       = 2;
    localparam logic [CFG_W-1:0] NUM_RESET   = 4'd2;
    localparam logic [CFG_W-1:0] DEN_RESET   = 4'd1;
    localparam logic [CFG_W-1:0] SHIFT_RESET = 4'd4;
    localparam logic [CFG_W-1:0] SHIFT_MAX   = 4'd8;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DIVIDER_NUM = 2'd0,
        REG_DIVIDER_DEN = 2'd1,
        REG_EMA_SHIFT   = 2'd2
    } cfg_reg_t;

    // voltage, percent and fixed point
    localparam int MV_W             = 16;
    localparam logic [MV_W-1:0] MV_MAX = 16'd65535;
    localparam int PCT_W            = 7;
    localparam int Q8_SH            = 8;
    localparam int AVG_W            = 15;
    localparam logic [AVG_W:0] Q8_HALF = 16'd128;

    // curve tables
    localparam int CURVE_POINTS     = 13;
    localparam int SEGMENTS         = CURVE_POINTS - 1;
    localparam int CMV_W            = 13;
    localparam int SPAN_W           = 8;

    typedef logic [CMV_W-1:0] cmv_t;
    typedef logic [PCT_W-1:0] pct_t;

    localparam cmv_t CHG_MV [CURVE_POINTS] = '{
        13'd3000, 13'd3200, 13'd3350, 13'd3450, 13'd3550, 13'd3630, 13'd3700,
        13'd3770, 13'd3820, 13'd3870, 13'd3920, 13'd4050, 13'd4200
    };
    localparam pct_t CHG_PCT [CURVE_POINTS] = '{
        7'd0, 7'd5, 7'd10, 7'd15, 7'd20, 7'd30, 7'd40,
        7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
    };
    localparam cmv_t DIS_MV [CURVE_POINTS] = '{
        13'd3000, 13'd3230, 13'd3380, 13'd3480, 13'd3600, 13'd3680, 13'd3750,
        13'd3820, 13'd3860, 13'd3910, 13'd3960, 13'd4080, 13'd4200
    };
    localparam pct_t DIS_PCT [CURVE_POINTS] = '{
        7'd0, 7'd5, 7'd10, 7'd15, 7'd20, 7'd30, 7'd40,
        7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
    };

    // shared divider, two quotient bits per cycle
    localparam int DIV_RAW_W        = PCT_W + SPAN_W + Q8_SH;
    localparam int DIV_NW           = ((DIV_RAW_W + 1) / 2) * 2;
    localparam int DIV_DW           = SPAN_W;
    localparam int DIV_ITER         = DIV_NW / 2;
    localparam int DIV_CNT_W        = $clog2(DIV_ITER);

    typedef logic [SAMPLES_PER_READ-1:0][SAMPLE_W-1:0] sample_vec_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } div_rsp_t;

    // what one curve segment lane reports
    typedef struct packed {
        logic              hit;
        logic [SPAN_W-1:0] off;
        logic [SPAN_W-1:0] span;
        pct_t              dpct;
        pct_t              base;
    } seg_t;

endpackage

`default_nettype wire

// File: rtl/ble_lane.sv
// ---------------------------------------------------------------------------
// ble_lane: one curve segment lane
// Checks whether the voltage falls in this segment and reports the
// offset into it, its span and its percent rise.
// ---------------------------------------------------------------------------
`default_nettype none

module ble_lane
    import ble_pkg::*;
(
    input  wire logic [MV_W-1:0] mv,
    input  wire cmv_t            lo_mv,
    input  wire cmv_t            hi_mv,
    input  wire pct_t            lo_pct,
    input  wire pct_t            hi_pct,
    output seg_t                 seg
);

    logic [MV_W-1:0]  lo_ext;
    logic [MV_W-1:0]  hi_ext;
    logic [MV_W-1:0]  off_full;
    cmv_t             span_full;

    // segment covers lo_mv up to but not including hi_mv
    always_comb
    begin
        lo_ext    = MV_W'(lo_mv);
        hi_ext    = MV_W'(hi_mv);
        off_full  = mv - lo_ext;
        span_full = hi_mv - lo_mv;
        seg.hit   = (mv >= lo_ext) && (mv < hi_ext);
        seg.off   = off_full[SPAN_W-1:0];
        seg.span  = span_full[SPAN_W-1:0];
        seg.dpct  = hi_pct - lo_pct;
        seg.base  = lo_pct;
    end

endmodule

`default_nettype wire

// File: rtl/ble_trim.sv
// ---------------------------------------------------------------------------
// ble_trim: trimmed sum of one reading
// Sums the samples and removes one copy of the smallest and the largest.
// ---------------------------------------------------------------------------
`default_nettype none

module ble_trim
    import ble_pkg::*;
(
    input  wire sample_vec_t       samples,
    output logic [SUM_W-1:0]       tsum
);

    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;

    // running sum, minimum and maximum
    always_comb
    begin
        sum = '0;
        lo  = '1;
        hi  = '0;
        for (int i = 0; i < SAMPLES_PER_READ; i++)
        begin
            sum = sum + SUM_W'(samples[i]);
            if (samples[i] < lo)
            begin
                lo = samples[i];
            end
            if (samples[i] > hi)
            begin
                hi = samples[i];
            end
        end
        tsum = sum - SUM_W'(lo) - SUM_W'(hi);
    end

endmodule

`default_nettype wire

// File: rtl/ble_div.sv
// ---------------------------------------------------------------------------
// ble_div: shared restoring divider
// Unsigned divide, two quotient bits per cycle; the quotient is valid
// in the cycle that done is high and holds until the next start.
// ---------------------------------------------------------------------------
`default_nettype none

module ble_div
    import ble_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NW-1:0]    work_reg;
    logic [DIV_NW-1:0]    work_next;
    logic [DIV_DW-1:0]    rem_reg;
    logic [DIV_DW-1:0]    rem_next;
    logic [DIV_DW-1:0]    dsr_reg;
    logic [DIV_DW:0]      trial;

    // two restoring steps: dividend shifts out the top, quotient in the bottom
    always_comb
    begin
        rem_next  = rem_reg;
        work_next = work_reg;
        trial     = '0;
        for (int k = 0; k < 2; k++)
        begin
            trial     = {rem_next, work_next[DIV_NW-1]};
            work_next = {work_next[DIV_NW-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial        = trial - {1'b0, dsr_reg};
                work_next[0] = 1'b1;
            end
            rem_next = trial[DIV_DW-1:0];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_ITER - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            work_reg <= req.dividend;
            rem_reg  <= '0;
            dsr_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = work_reg;

endmodule

`default_nettype wire

// File: rtl/battery_level_estimator.sv
// ---------------------------------------------------------------------------
// battery_level_estimator: battery voltage and charge percent estimator
// Trimmed mean of eight samples, divider ratio scaling, curve lookup with
// linear interpolation and an exponential average of the percent.
//   Input beat: sample_0..sample_7 and charging on in_valid; taken when
//   in_stall is low. Output beat: battery_mv, level_pct, smoothed_pct and
//   charging_echo on out_valid; taken when out_stall is low.
//   One beat at a time is worked on. It passes the trim, mean, scale and
//   voltage divide steps, then the segment step and, only when the voltage
//   lies inside the curve, a percent divide pass of the shared divider,
//   then the average step. The next input beat is taken the cycle after the
//   result is written. The curve segment itself is found by parallel
//   combinational lanes.
//   A finished result waits in the output register while the next beat is
//   already taken; when the receiver stalls, the block holds its result in
//   the final step until the output register frees up.
//   Configuration writes (cfg_en, cfg_addr, cfg_data) are for idle times;
//   reset restores the register defaults and clears the average seed.
// ---------------------------------------------------------------------------
`default_nettype none

module battery_level_estimator
    import ble_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_data,
    // input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [SAMPLE_W-1:0]   sample_0,
    input  wire logic [SAMPLE_W-1:0]   sample_1,
    input  wire logic [SAMPLE_W-1:0]   sample_2,
    input  wire logic [SAMPLE_W-1:0]   sample_3,
    input  wire logic [SAMPLE_W-1:0]   sample_4,
    input  wire logic [SAMPLE_W-1:0]   sample_5,
    input  wire logic [SAMPLE_W-1:0]   sample_6,
    input  wire logic [SAMPLE_W-1:0]   sample_7,
    input  wire logic                  charging,
    // output channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [MV_W-1:0]            battery_mv,
    output logic [PCT_W-1:0]           level_pct,
    output logic [PCT_W-1:0]           smoothed_pct,
    output logic                       charging_echo
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_TRIM  = 8'b0000_0010,
        ST_MEAN  = 8'b0000_0100,
        ST_SCALE = 8'b0000_1000,
        ST_DIV_V = 8'b0001_0000,
        ST_SEG   = 8'b0010_0000,
        ST_DIV_P = 8'b0100_0000,
        ST_EMA   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration registers
    logic [CFG_W-1:0] num_reg;
    logic [CFG_W-1:0] den_reg;
    logic [CFG_W-1:0] shift_reg;
    logic [CFG_W-1:0] den_eff;
    logic [CFG_W-1:0] shift_eff;

    // item datapath
    logic [SAMPLE_W-1:0]         field_vec [NUM_SAMPLE_PORTS];
    sample_vec_t                 samples_next;
    sample_vec_t                 samples_reg;
    logic                        charging_reg;
    logic [SUM_W-1:0]            tsum;
    logic [SUM_W-1:0]            tsum_reg;
    logic [SUM_W+RECIP_W-1:0]    mean_prod;
    logic [SAMPLE_W-1:0]         mean_reg;
    logic [SAMPLE_W+CFG_W-1:0]   scale_prod;
    logic [MV_W-1:0]             vbat_sat;
    logic [MV_W-1:0]             vbat_reg;
    logic [PCT_W+SPAN_W-1:0]     interp_prod;
    pct_t                        base_reg;
    logic [AVG_W:0]              pct_q8;
    pct_t                        pct_reg;

    // curve lanes
    cmv_t                        pt_mv  [CURVE_POINTS];
    pct_t                        pt_pct [CURVE_POINTS];
    seg_t                        lane_seg [SEGMENTS];
    seg_t                        seg_m;
    logic                        below;
    logic                        above;

    // divider
    div_req_t                    div_req;
    div_rsp_t                    div_rsp;

    // average
    logic                        seeded_reg;
    logic [AVG_W-1:0]            avg_reg;
    logic [AVG_W-1:0]            avg_new;
    logic [AVG_W-1:0]            target;
    logic signed [AVG_W:0]       diff;
    logic signed [AVG_W:0]       step;
    logic [AVG_W:0]              sm_sum;
    pct_t                        sm_pct;

    // output register
    logic                        out_load;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [MV_W-1:0]             battery_mv_reg;
    pct_t                        level_pct_reg;
    pct_t                        smoothed_pct_reg;
    logic                        charging_echo_reg;

    // register values outside their meaningful range
    assign den_eff   = (den_reg == '0) ? CFG_W'(1) : den_reg;
    assign shift_eff = (shift_reg > SHIFT_MAX) ? SHIFT_MAX : shift_reg;

    // gather the sample ports, keep the ones in use
    always_comb
    begin
        field_vec[0] = sample_0;
        field_vec[1] = sample_1;
        field_vec[2] = sample_2;
        field_vec[3] = sample_3;
        field_vec[4] = sample_4;
        field_vec[5] = sample_5;
        field_vec[6] = sample_6;
        field_vec[7] = sample_7;
        for (int i = 0; i < SAMPLES_PER_READ; i++)
        begin
            samples_next[i] = field_vec[i];
        end
    end

    ble_trim u_trim (
        .samples (samples_reg),
        .tsum    (tsum)
    );

    // divide by the kept sample count, then scale by the numerator
    assign mean_prod  = (SUM_W+RECIP_W)'(tsum_reg) * (SUM_W+RECIP_W)'(RECIP);
    assign scale_prod = (SAMPLE_W+CFG_W)'(mean_reg) * (SAMPLE_W+CFG_W)'(num_reg);
    assign vbat_sat   = (div_rsp.quotient[DIV_NW-1:MV_W] != '0) ? MV_MAX
                                                               : div_rsp.quotient[MV_W-1:0];

    // selected curve
    always_comb
    begin
        for (int i = 0; i < CURVE_POINTS; i++)
        begin
            pt_mv[i]  = charging_reg ? CHG_MV[i]  : DIS_MV[i];
            pt_pct[i] = charging_reg ? CHG_PCT[i] : DIS_PCT[i];
        end
    end

    // one lane per curve segment
    for (genvar g = 0; g < SEGMENTS; g++)
    begin : g_lane
        ble_lane u_lane (
            .mv     (vbat_reg),
            .lo_mv  (pt_mv[g]),
            .hi_mv  (pt_mv[g+1]),
            .lo_pct (pt_pct[g]),
            .hi_pct (pt_pct[g+1]),
            .seg    (lane_seg[g])
        );
    end

    // merge: at most one lane hits
    always_comb
    begin
        seg_m = '0;
        for (int j = 0; j < SEGMENTS; j++)
        begin
            if (lane_seg[j].hit)
            begin
                seg_m = seg_m | lane_seg[j];
            end
        end
        below = vbat_reg <= MV_W'(pt_mv[0]);
        above = vbat_reg >= MV_W'(pt_mv[CURVE_POINTS-1]);
    end

    // interpolation numerator and rounding of the Q8 percent
    assign interp_prod = (PCT_W+SPAN_W)'(seg_m.dpct) * (PCT_W+SPAN_W)'(seg_m.off);
    assign pct_q8      = (AVG_W+1)'({base_reg, {Q8_SH{1'b0}}})
                       + div_rsp.quotient[AVG_W:0] + Q8_HALF;

    ble_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // divider requests: voltage scaling, then segment interpolation
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = DIV_NW'(scale_prod);
        div_req.divisor  = DIV_DW'(den_eff);
        if (state_reg == ST_SCALE)
        begin
            div_req.start = 1'b1;
        end
        else if (state_reg == ST_SEG)
        begin
            div_req.start    = !(below || above);
            div_req.dividend = DIV_NW'({interp_prod, {Q8_SH{1'b0}}});
            div_req.divisor  = seg_m.span;
        end
    end

    // exponential average update
    always_comb
    begin
        target = {pct_reg, {Q8_SH{1'b0}}};
        diff   = $signed({1'b0, target}) - $signed({1'b0, avg_reg});
        step   = diff >>> shift_eff;
        if (seeded_reg)
        begin
            avg_new = avg_reg + step[AVG_W-1:0];
        end
        else
        begin
            avg_new = target;
        end
        sm_sum = {1'b0, avg_new} + Q8_HALF;
        sm_pct = sm_sum[Q8_SH +: PCT_W];
    end

    // output register handshake
    assign out_load       = (state_reg == ST_EMA) && (!out_valid_reg || !out_stall);
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:  state_next = ST_MEAN;
            ST_MEAN:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV_V;
            ST_DIV_V:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_SEG;
                end
            end
            ST_SEG:
            begin
                if (below || above)
                begin
                    state_next = ST_EMA;
                end
                else
                begin
                    state_next = ST_DIV_P;
                end
            end
            ST_DIV_P:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_EMA;
                end
            end
            ST_EMA:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            num_reg       <= NUM_RESET;
            den_reg       <= DEN_RESET;
            shift_reg     <= SHIFT_RESET;
            seeded_reg    <= 1'b0;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_en)
            begin
                case (cfg_addr)
                    REG_DIVIDER_NUM: num_reg   <= cfg_data;
                    REG_DIVIDER_DEN: den_reg   <= cfg_data;
                    REG_EMA_SHIFT:   shift_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (out_load)
            begin
                seeded_reg <= 1'b1;
                avg_reg    <= avg_new;
            end
        end
    end

    // item datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            samples_reg  <= samples_next;
            charging_reg <= charging;
        end
        if (state_reg == ST_TRIM)
        begin
            tsum_reg <= tsum;
        end
        if (state_reg == ST_MEAN)
        begin
            mean_reg <= mean_prod[RECIP_SH +: SAMPLE_W];
        end
        if (state_reg == ST_DIV_V && div_rsp.done)
        begin
            vbat_reg <= vbat_sat;
        end
        if (state_reg == ST_SEG)
        begin
            base_reg <= seg_m.base;
            if (below)
            begin
                pct_reg <= pt_pct[0];
            end
            else if (above)
            begin
                pct_reg <= pt_pct[CURVE_POINTS-1];
            end
        end
        if (state_reg == ST_DIV_P && div_rsp.done)
        begin
            pct_reg <= pct_q8[Q8_SH +: PCT_W];
        end
        if (out_load)
        begin
            battery_mv_reg    <= vbat_reg;
            level_pct_reg     <= pct_reg;
            smoothed_pct_reg  <= sm_pct;
            charging_echo_reg <= charging_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign battery_mv    = battery_mv_reg;
    assign level_pct     = level_pct_reg;
    assign smoothed_pct  = smoothed_pct_reg;
    assign charging_echo = charging_echo_reg;

    // checks
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_V || state_reg == ST_DIV_P))
        else $error("divider result with no step waiting for it");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level_pct <= PCT_W'(100) && smoothed_pct <= PCT_W'(100)))
        else $error("percent out of range");

    a_seed_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (seeded_reg && out_valid))
        else $error("result write did not seed the average");

endmodule

`default_nettype wire

// File: tb/battery_level_estimator_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// battery_level_estimator_tb: self-checking bench for the battery estimator
// Directed beats cover the curve ends and knees, the sample trimming,
// the divider ratio registers and the smoothing shift. A random part then
// sends readings aimed at the curve range, with some noise, under several
// register settings and idle patterns. Every result beat is compared field
// by field with the bench's own estimate of voltage, percent and average.
// ---------------------------------------------------------------------------

module battery_level_estimator_tb;

    import ble_pkg::*;

    localparam int          CYCLE_LIMIT   = 600000;
    localparam int          RANDOM_ITEMS  = 750;
    localparam int          RANDOM_BLOCKS = 8;
    localparam int          DRAIN_CYCLES  = 40;
    localparam int unsigned KNEES         = 13;

    // charge curves, knee 0 in the lowest slot
    localparam logic [KNEES-1:0][15:0] CHARGE_KNEE_MV = {
        16'd4200, 16'd4050, 16'd3920, 16'd3870, 16'd3820, 16'd3770, 16'd3700,
        16'd3630, 16'd3550, 16'd3450, 16'd3350, 16'd3200, 16'd3000
    };
    localparam logic [KNEES-1:0][15:0] DISCHARGE_KNEE_MV = {
        16'd4200, 16'd4080, 16'd3960, 16'd3910, 16'd3860, 16'd3820, 16'd3750,
        16'd3680, 16'd3600, 16'd3480, 16'd3380, 16'd3230, 16'd3000
    };
    localparam logic [KNEES-1:0][7:0] KNEE_PCT = {
        8'd100, 8'd90, 8'd80, 8'd70, 8'd60, 8'd50, 8'd40,
        8'd30, 8'd20, 8'd15, 8'd10, 8'd5, 8'd0
    };

    typedef logic [NUM_SAMPLE_PORTS-1:0][SAMPLE_W-1:0] sample_set_t;

    typedef struct packed {
        logic [MV_W-1:0]  battery_mv;
        logic [PCT_W-1:0] level_pct;
        logic [PCT_W-1:0] smoothed_pct;
        logic             charging_echo;
    } reading_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample_0;
    logic [SAMPLE_W-1:0]   sample_1;
    logic [SAMPLE_W-1:0]   sample_2;
    logic [SAMPLE_W-1:0]   sample_3;
    logic [SAMPLE_W-1:0]   sample_4;
    logic [SAMPLE_W-1:0]   sample_5;
    logic [SAMPLE_W-1:0]   sample_6;
    logic [SAMPLE_W-1:0]   sample_7;
    logic                  charging;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [MV_W-1:0]       battery_mv;
    logic [PCT_W-1:0]      level_pct;
    logic [PCT_W-1:0]      smoothed_pct;
    logic                  charging_echo;

    // bench copy of the registers and the running average
    logic [CFG_W-1:0] div_num;
    logic [CFG_W-1:0] div_den;
    logic [CFG_W-1:0] smooth_shift;
    bit               avg_seeded;
    int unsigned      avg_q8;

    reading_t    pending_readings[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct       = 0;

    battery_level_estimator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_en        (cfg_en),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_0      (sample_0),
        .sample_1      (sample_1),
        .sample_2      (sample_2),
        .sample_3      (sample_3),
        .sample_4      (sample_4),
        .sample_5      (sample_5),
        .sample_6      (sample_6),
        .sample_7      (sample_7),
        .charging      (charging),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .battery_mv    (battery_mv),
        .level_pct     (level_pct),
        .smoothed_pct  (smoothed_pct),
        .charging_echo (charging_echo)
    );

    // clock
    always
    begin
        #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // percent from piecewise-linear curve, rounded from q8
    function automatic int unsigned curve_percent(int unsigned mv, bit chg);
        int unsigned seg;
        int unsigned i;
        int unsigned lo_mv;
        int unsigned hi_mv;
        int unsigned q8;
        seg = 0;
        if (mv <= (chg ? CHARGE_KNEE_MV[0] : DISCHARGE_KNEE_MV[0]))
            return KNEE_PCT[0];
        if (mv >= (chg ? CHARGE_KNEE_MV[KNEES-1] : DISCHARGE_KNEE_MV[KNEES-1]))
            return KNEE_PCT[KNEES-1];
        for (i = 1; i < KNEES - 1; i++)
        begin
            if (mv >= (chg ? CHARGE_KNEE_MV[i] : DISCHARGE_KNEE_MV[i]))
                seg = i;
        end
        lo_mv = chg ? CHARGE_KNEE_MV[seg] : DISCHARGE_KNEE_MV[seg];
        hi_mv = chg ? CHARGE_KNEE_MV[seg+1] : DISCHARGE_KNEE_MV[seg+1];
        q8 = KNEE_PCT[seg] * 256
           + ((KNEE_PCT[seg+1] - KNEE_PCT[seg]) * 256 * (mv - lo_mv)) / (hi_mv - lo_mv);
        return (q8 + 128) >> 8;
    endfunction

    // expected result of one reading; advances the running average
    function automatic reading_t estimate_reading(sample_set_t s, bit chg);
        reading_t    r;
        int unsigned total;
        int unsigned lo;
        int unsigned hi;
        int unsigned den;
        int unsigned volts;
        int unsigned pct;
        int unsigned sh;
        int unsigned target;
        int unsigned i;
        total = 0;
        lo = 4095;
        hi = 0;
        for (i = 0; i < SAMPLES_PER_READ; i++)
        begin
            total += s[i];
            if (s[i] < lo) lo = s[i];
            if (s[i] > hi) hi = s[i];
        end
        den = (div_den == 0) ? 1 : div_den;
        volts = ((total - lo - hi) / (SAMPLES_PER_READ - 2)) * div_num / den;
        if (volts > 65535) volts = 65535;
        pct = curve_percent(volts, chg);

        // seed on first reading, otherwise step toward the new percent
        target = pct * 256;
        if (!avg_seeded)
        begin
            avg_seeded = 1'b1;
            avg_q8 = target;
        end
        else
        begin
            sh = (smooth_shift > 8) ? 8 : smooth_shift;
            if (target >= avg_q8)
                avg_q8 = avg_q8 + ((target - avg_q8) >> sh);
            else
                avg_q8 = avg_q8 - ((avg_q8 - target + (1 << sh) - 1) >> sh);
            avg_q8 = avg_q8 & 32'h7FFF;
        end

        r.battery_mv    = volts[MV_W-1:0];
        r.level_pct     = pct[PCT_W-1:0];
        r.smoothed_pct  = PCT_W'((avg_q8 + 128) >> 8);
        r.charging_echo = chg;
        return r;
    endfunction

    function automatic sample_set_t flat_set(int unsigned mv);
        return {NUM_SAMPLE_PORTS{SAMPLE_W'(mv)}};
    endfunction

    task automatic note_mismatch(string what, int unsigned want, int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // result beat checker
    always @(posedge clk)
    begin : check_results
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                note_mismatch("unexpected result beat", 0, 1);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (battery_mv !== want.battery_mv)
                    note_mismatch("battery_mv", want.battery_mv, battery_mv);
                if (level_pct !== want.level_pct)
                    note_mismatch("level_pct", want.level_pct, level_pct);
                if (smoothed_pct !== want.smoothed_pct)
                    note_mismatch("smoothed_pct", want.smoothed_pct, smoothed_pct);
                if (charging_echo !== want.charging_echo)
                    note_mismatch("charging_echo", want.charging_echo, charging_echo);
            end
        end
    end

    // one input beat, with random sender gaps ahead of it
    task automatic send_reading(sample_set_t s, bit chg);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_0 <= s[0];
        sample_1 <= s[1];
        sample_2 <= s[2];
        sample_3 <= s[3];
        sample_4 <= s[4];
        sample_5 <= s[5];
        sample_6 <= s[6];
        sample_7 <= s[7];
        charging <= chg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_readings.push_back(estimate_reading(s, chg));
    endtask

    // drop valid and let every pending result come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(cfg_reg_t idx, logic [CFG_W-1:0] value);
        cfg_en   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DIVIDER_NUM: div_num = value;
            REG_DIVIDER_DEN: div_den = value;
            REG_EMA_SHIFT:   smooth_shift = value;
            default: ;
        endcase
    endtask

    // reset defaults, first reading seeds the average, voltage extremes
    task automatic test_reset_defaults();
        send_reading(flat_set(1500), 1'b0);
        send_reading(flat_set(2100), 1'b1);
        send_reading(flat_set(0), 1'b0);
        send_reading(flat_set(4095), 1'b1);
        wait_idle();
    endtask

    // knees, interior points and sample trimming
    task automatic test_curve_points();
        send_reading(flat_set(1615), 1'b0);
        send_reading(flat_set(1600), 1'b1);
        send_reading(flat_set(1501), 1'b1);
        send_reading(flat_set(2099), 1'b0);
        send_reading(flat_set(1885), 1'b1);
        send_reading(flat_set(1885), 1'b0);
        // outliers at both ends dropped
        send_reading({12'd1800, 12'd1800, 12'd1800, 12'd4095,
                      12'd1800, 12'd1800, 12'd0, 12'd1800}, 1'b0);
        // repeated min and max, only one copy of each dropped
        send_reading({12'd1600, 12'd1600, 12'd1600, 12'd1900,
                      12'd1900, 12'd1700, 12'd1700, 12'd1700}, 1'b1);
        // truncating mean
        send_reading({12'd1801, 12'd1802, 12'd1800, 12'd1800,
                      12'd1800, 12'd1800, 12'd1800, 12'd1800}, 1'b0);
        wait_idle();
    endtask

    // divider ratio, zero numerator and zero denominator
    task automatic test_divider_ratio();
        write_register(REG_DIVIDER_NUM, 4'd0);
        send_reading(flat_set(2000), 1'b1);
        wait_idle();
        write_register(REG_DIVIDER_NUM, 4'd15);
        write_register(REG_DIVIDER_DEN, 4'd0);
        send_reading(flat_set(4095), 1'b0);
        wait_idle();
        write_register(REG_DIVIDER_NUM, 4'd1);
        write_register(REG_DIVIDER_DEN, 4'd15);
        send_reading(flat_set(4095), 1'b1);
        wait_idle();
        write_register(REG_DIVIDER_NUM, 4'd15);
        send_reading(flat_set(3600), 1'b0);
        wait_idle();
        write_register(REG_DIVIDER_NUM, 4'd7);
        write_register(REG_DIVIDER_DEN, 4'd5);
        send_reading(flat_set(2700), 1'b1);
        wait_idle();
        write_register(REG_DIVIDER_NUM, 4'd2);
        write_register(REG_DIVIDER_DEN, 4'd1);
    endtask

    // smoothing shift at zero, at max and above max
    task automatic test_smoothing_shift();
        write_register(REG_EMA_SHIFT, 4'd0);
        send_reading(flat_set(1500), 1'b0);
        send_reading(flat_set(2100), 1'b1);
        wait_idle();
        write_register(REG_EMA_SHIFT, 4'd8);
        send_reading(flat_set(1500), 1'b0);
        send_reading(flat_set(2100), 1'b0);
        wait_idle();
        write_register(REG_EMA_SHIFT, 4'd15);
        send_reading(flat_set(1500), 1'b1);
        send_reading(flat_set(1800), 1'b0);
        wait_idle();
        write_register(REG_EMA_SHIFT, 4'd3);
        send_reading(flat_set(1850), 1'b1);
        wait_idle();
    endtask

    // random readings over several settings and idle patterns
    task automatic test_random_traffic();
        int          blk;
        int          n;
        int          i;
        int          mean;
        int          jitter;
        int          v;
        int unsigned den_eff;
        int unsigned num;
        sample_set_t s;
        bit          chg;
        for (blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            wait_idle();
            case (blk)
                0: begin write_register(REG_DIVIDER_NUM, 4'd1);
                         write_register(REG_DIVIDER_DEN, 4'd1);
                         write_register(REG_EMA_SHIFT, 4'd0); end
                1: begin write_register(REG_DIVIDER_NUM, 4'd15);
                         write_register(REG_DIVIDER_DEN, 4'd15);
                         write_register(REG_EMA_SHIFT, 4'd8); end
                2: begin write_register(REG_DIVIDER_NUM, 4'd5);
                         write_register(REG_DIVIDER_DEN, 4'd4);
                         write_register(REG_EMA_SHIFT, 4'd15); end
                3: begin write_register(REG_DIVIDER_NUM, 4'd15);
                         write_register(REG_DIVIDER_DEN, 4'd4);
                         write_register(REG_EMA_SHIFT, 4'd1); end
                default:
                begin
                    num = $urandom_range(1, 15);
                    write_register(REG_DIVIDER_NUM, CFG_W'(num));
                    write_register(REG_DIVIDER_DEN, CFG_W'($urandom_range(0, num)));
                    write_register(REG_EMA_SHIFT, CFG_W'($urandom_range(0, 15)));
                end
            endcase

            // idle pattern for this block
            case (blk % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 49; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 49; end
                default: begin sender_idle_pct = 6; stall_pct = 6; end
            endcase

            for (n = 0; n < RANDOM_ITEMS / RANDOM_BLOCKS; n++)
            begin
                chg = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < 20)
                begin
                    // full-range noise
                    for (i = 0; i < NUM_SAMPLE_PORTS; i++)
                        s[i] = SAMPLE_W'($urandom_range(0, 4095));
                end
                else
                begin
                    // aim the scaled mean at the curve range
                    den_eff = (div_den == 0) ? 1 : div_den;
                    mean = ($urandom_range(2950, 4250) * den_eff) / div_num;
                    if (mean > 4095) mean = 4095;
                    jitter = $urandom_range(0, 3) * 15;
                    for (i = 0; i < NUM_SAMPLE_PORTS; i++)
                    begin
                        v = mean + $urandom_range(0, 2 * jitter) - jitter;
                        if (v < 0) v = 0;
                        if (v > 4095) v = 4095;
                        s[i] = SAMPLE_W'(v);
                    end
                    if ($urandom_range(0, 3) == 0)
                        s[$urandom_range(0, NUM_SAMPLE_PORTS - 1)] =
                            SAMPLE_W'($urandom_range(0, 4095));
                end
                send_reading(s, chg);
            end
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        cfg_en   <= 1'b0;
        cfg_addr <= REG_DIVIDER_NUM;
        cfg_data <= '0;
        in_valid <= 1'b0;
        sample_0 <= '0;
        sample_1 <= '0;
        sample_2 <= '0;
        sample_3 <= '0;
        sample_4 <= '0;
        sample_5 <= '0;
        sample_6 <= '0;
        sample_7 <= '0;
        charging <= 1'b0;
        div_num      = 4'd2;
        div_den      = 4'd1;
        smooth_shift = 4'd4;
        avg_seeded   = 1'b0;
        avg_q8       = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_curve_points();
        test_divider_ratio();
        test_smoothing_shift();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ble_pkg.sv
rtl/ble_lane.sv
rtl/ble_trim.sv
rtl/ble_div.sv
rtl/battery_level_estimator.sv
tb/battery_level_estimator_tb.sv
